### src/size_class_pool_allocator_top_assert.svh
// assertion macros for the size class pool allocator
`ifndef SIZE_CLASS_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_TOP_ASSERT_SVH

// condition in this cycle implies property in the same cycle
`define SCPA_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("allocator assertion failed");

// condition in this cycle implies property in the next cycle
`define SCPA_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("allocator assertion failed");

`endif

### src/scpa_pkg.sv
package scpa_pkg;

    // allocator sizing
    localparam int POOL_BYTES  = 4096;
    localparam int POOL_COUNT  = 8;
    localparam int STACK_DEPTH = 16;

    // derived sizes
    localparam int CLASS_COUNT = POOL_BYTES / 8;
    localparam int CLS_W       = $clog2(CLASS_COUNT);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int FILL_W      = $clog2(POOL_BYTES + 1);
    localparam int POOL_W      = $clog2(POOL_COUNT + 1);
    localparam int POOL_IDX_W  = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int STORE_DEPTH = CLASS_COUNT * STACK_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int UNITS_W     = 14;
    localparam int POOL_UNITS  = POOL_BYTES / 8;

    // field widths
    localparam int REQ_W    = 16;
    localparam int ADDR_W   = 15;
    localparam int STATUS_W = 3;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED    = 3'd0,
        ST_EXISTING  = 3'd1,
        ST_NEW_POOL  = 3'd2,
        ST_FREED     = 3'd3,
        ST_IGNORED   = 3'd4,
        ST_TOO_LARGE = 3'd5,
        ST_NO_POOL   = 3'd6,
        ST_LIST_FULL = 3'd7
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT,
        S_POP,
        S_SCAN,
        S_OUT
    } t_state;

endpackage

### src/size_class_pool_allocator_top.sv
// A zero or oversize request goes from S_IDLE straight to S_OUT, a free passes through S_CNT,
// a reuse through S_CNT and S_POP, and a carve through S_CNT and S_SCAN, which steps the open pools.
// One request at a time; the next is taken only once the result is handed to the output register,
// and S_OUT waits while that register still holds a result that has not been accepted.
// The free stack counts live in a memory cleared by a pass after reset (one class per
// cycle); no request is taken until it is done.
module size_class_pool_allocator_top
    import scpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // request_size[15:0], chunk_address[30:16], zero pad
    input  logic [0:0]  s_axis_tuser,  // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // granted_address[14:0], zero pad
    output logic [2:0]  m_axis_tuser   // status[2:0]
);

    // registers
    t_state              r_state, n_state;
    logic [CLS_W-1:0]    r_clr_idx, n_clr_idx;
    logic                r_mode, n_mode;
    logic [ADDR_W-1:0]   r_caddr, n_caddr;
    logic [FILL_W-1:0]   r_size, n_size;
    logic [CLS_W-1:0]    r_cls, n_cls;
    logic [POOL_W-1:0]   r_pool, n_pool;
    logic [POOL_W-1:0]   r_pools_open, n_pools_open;
    logic [FILL_W-1:0]   r_fill [POOL_COUNT];
    logic [FILL_W-1:0]   n_fill [POOL_COUNT];
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    t_status             r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    t_status             r_out_status, n_out_status;

    // memory ports
    logic                cnt_we;
    logic [CLS_W-1:0]    cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [CLS_W-1:0]    cnt_raddr;
    logic [CNT_W-1:0]    cnt_rdata;
    logic                stk_we;
    logic [STORE_AW-1:0] stk_waddr;
    logic [ADDR_W-1:0]   stk_wdata;
    logic [STORE_AW-1:0] stk_raddr;
    logic [ADDR_W-1:0]   stk_rdata;

    // input decode
    logic [REQ_W-1:0]    in_req;
    logic [ADDR_W-1:0]   in_caddr;
    logic [REQ_W:0]      in_rnd;
    logic [UNITS_W-1:0]  in_units;
    logic [CLS_W-1:0]    in_cls;
    logic                in_zero;
    logic                in_too_large;
    logic                in_xfer;

    assign in_req       = s_axis_tdata[15:0];
    assign in_caddr     = s_axis_tdata[30:16];
    assign in_rnd       = {1'b0, in_req} + 17'd7;
    assign in_units     = in_rnd[REQ_W:3];
    assign in_cls       = CLS_W'(in_units - 14'd1);
    assign in_zero      = (in_req == '0);
    assign in_too_large = (in_units > UNITS_W'(POOL_UNITS));
    assign in_xfer      = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_addr};
    assign m_axis_tuser  = r_out_status;

    // stack count per size class
    scpa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CLASS_COUNT)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // freed chunk addresses, one stack per size class
    scpa_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STORE_DEPTH)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // stack slot addresses
    logic [STORE_AW-1:0] stk_base;
    logic [FILL_W-1:0]   scan_fill;
    logic [FILL_W:0]     scan_sum;

    assign stk_base  = STORE_AW'(r_cls) * STORE_AW'(STACK_DEPTH);
    assign scan_fill = r_fill[r_pool[POOL_IDX_W-1:0]];
    assign scan_sum  = {1'b0, scan_fill} + {1'b0, r_size};

    // next state and memory control
    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_mode       = r_mode;
        n_caddr      = r_caddr;
        n_size       = r_size;
        n_cls        = r_cls;
        n_pool       = r_pool;
        n_pools_open = r_pools_open;
        n_fill       = r_fill;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        cnt_we       = 1'b0;
        cnt_waddr    = r_cls;
        cnt_wdata    = '0;
        cnt_raddr    = in_cls;
        stk_we       = 1'b0;
        stk_waddr    = stk_base + STORE_AW'(cnt_rdata);
        stk_wdata    = r_caddr;
        stk_raddr    = stk_base + STORE_AW'(cnt_rdata - CNT_W'(1));

        unique case (r_state)
            // zero every class count after reset
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr_idx;
                cnt_wdata = '0;
                n_clr_idx = r_clr_idx + CLS_W'(1);
                if (r_clr_idx == CLS_W'(CLASS_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // take a request, look up its class count
            S_IDLE: begin
                if (in_xfer) begin
                    n_mode     = s_axis_tuser[0];
                    n_caddr    = in_caddr;
                    n_size     = FILL_W'({in_units, 3'b000});
                    n_cls      = in_cls;
                    n_res_addr = '0;
                    if (in_zero) begin
                        n_res_status = ST_IGNORED;
                        n_state      = S_OUT;
                    end else if (in_too_large) begin
                        n_res_status = ST_TOO_LARGE;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_CNT;
                    end
                end
            end
            // push, pop or fall through to the pool scan
            S_CNT: begin
                if (r_mode) begin
                    if (cnt_rdata < CNT_W'(STACK_DEPTH)) begin
                        stk_we       = 1'b1;
                        cnt_we       = 1'b1;
                        cnt_wdata    = cnt_rdata + CNT_W'(1);
                        n_res_status = ST_FREED;
                    end else begin
                        n_res_status = ST_LIST_FULL;
                    end
                    n_state = S_OUT;
                end else if (cnt_rdata != '0) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata - CNT_W'(1);
                    n_state   = S_POP;
                end else begin
                    n_pool  = '0;
                    n_state = S_SCAN;
                end
            end
            // popped address arrives from the store
            S_POP: begin
                n_res_addr   = stk_rdata;
                n_res_status = ST_REUSED;
                n_state      = S_OUT;
            end
            // one pool fill level per cycle until one has room, else open a new pool if any remain
            S_SCAN: begin
                if (r_pool == r_pools_open) begin
                    if (r_pools_open < POOL_W'(POOL_COUNT)) begin
                        n_fill[r_pools_open[POOL_IDX_W-1:0]] = r_size;
                        n_pools_open = r_pools_open + POOL_W'(1);
                        n_res_addr   = ADDR_W'(32'(r_pools_open) * 32'(POOL_BYTES));
                        n_res_status = ST_NEW_POOL;
                    end else begin
                        n_res_status = ST_NO_POOL;
                    end
                    n_state = S_OUT;
                end else if (scan_sum <= (FILL_W+1)'(POOL_BYTES)) begin
                    n_fill[r_pool[POOL_IDX_W-1:0]] = scan_sum[FILL_W-1:0];
                    n_res_addr   = ADDR_W'(32'(r_pool) * 32'(POOL_BYTES) + 32'(scan_fill));
                    n_res_status = ST_EXISTING;
                    n_state      = S_OUT;
                end else begin
                    n_pool = r_pool + POOL_W'(1);
                end
            end
            // hand the result to the output register once it is free
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_pools_open <= '0;
            r_out_valid  <= 1'b0;
            r_fill       <= '{default: '0};
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_pools_open <= n_pools_open;
            r_out_valid  <= n_out_valid;
            r_fill       <= n_fill;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_caddr      <= n_caddr;
        r_size       <= n_size;
        r_cls        <= n_cls;
        r_pool       <= n_pool;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    `include "size_class_pool_allocator_top_assert.svh"

    // a push never lands beyond the top of its stack
    `SCPA_ASSERT_IMP(a_push_in_range, stk_we, cnt_rdata < CNT_W'(STACK_DEPTH))
    // never more pools open than exist
    `SCPA_ASSERT_IMP(a_pools_bounded, 1'b1, r_pools_open <= POOL_W'(POOL_COUNT))
    // an open pool never holds more than its size
    `SCPA_ASSERT_IMP(a_fill_bounded, (r_state == S_SCAN) && (r_pool < r_pools_open),
                     scan_fill <= FILL_W'(POOL_BYTES))
    // an accepted request always leaves the idle state
    `SCPA_ASSERT_NXT(a_xfer_busy, in_xfer, r_state != S_IDLE)

endmodule

### src/scpa_ram.sv
module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
